>>> rtl/dsad_pkg.sv
// Shared types and constants for the dust sample averaging and density block.
`timescale 1ns / 1ps
`default_nettype none

package dsad_pkg;

   typedef logic [11:0] sample_type;
   typedef logic [15:0] volt_type;
   typedef logic [21:0] dens_type;
   typedef logic [4:0]  gain_type;
   typedef logic [11:0] csr_data_type;

   typedef enum logic [0:0] {
      CSR_DENSITY_OFFSET = 1'b0,
      CSR_DIVIDER_GAIN   = 1'b1
   } csr_index_type;

   typedef struct packed {
      sample_type density_offset_mv;
      gain_type   divider_gain;
   } cfg_type;

   localparam sample_type OFFSET_RESET = 12'd400;
   localparam gain_type   GAIN_RESET   = 5'd11;

   // 3300 mV full scale in 1/16 mV units
   localparam volt_type MV_Q4    = 16'd52800;
   localparam volt_type VOLT_MAX = 16'hFFFF;
   localparam int       Q4_SHIFT = 4;

   // voltage times gain, and the divide-by-five reciprocal
   localparam int SCALED_W   = 21;
   localparam int DRECIP_W   = 22;
   localparam int DENS_K     = 24;
   localparam int DENS_Q_W   = SCALED_W + DRECIP_W - DENS_K;
   localparam logic [DRECIP_W-1:0] DENS_RECIP = 22'd3355444;

endpackage

`default_nettype wire

>>> rtl/dsad_req_if.sv
// Sample input channel: valid, ready and one converter sample.
`timescale 1ns / 1ps
`default_nettype none

interface dsad_req_if;
   import dsad_pkg::*;

   logic       valid;
   logic       ready;
   sample_type adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/dsad_rsp_if.sv
// Result channel: valid, ready, averaged sample, voltage and density.
`timescale 1ns / 1ps
`default_nettype none

interface dsad_rsp_if;
   import dsad_pkg::*;

   logic       valid;
   logic       ready;
   sample_type averaged_sample;
   volt_type   voltage_q4;
   dens_type   density_q4;

   modport source (output valid, output averaged_sample, output voltage_q4,
                   output density_q4, input ready);
   modport sink   (input valid, input averaged_sample, input voltage_q4,
                   input density_q4, output ready);
endinterface

`default_nettype wire

>>> rtl/dsad_cell.sv
// One window cell: holds a sample and on each beat takes the previous cell's sample, or the fill value when filling.
`timescale 1ns / 1ps
`default_nettype none

module dsad_cell (
   input  wire logic              clock,
   input  wire logic              shift_en,
   input  wire logic              fill_en,
   input  wire dsad_pkg::sample_type fill_value,
   input  wire dsad_pkg::sample_type shift_in,
   output dsad_pkg::sample_type   shift_out
);
   import dsad_pkg::*;

   sample_type data_ff;
   sample_type data_in;

   assign data_in   = fill_en ? fill_value : shift_in;
   assign shift_out = data_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/dsad_window.sv
// Sliding window: row of sample cells, running sum and average stage.
`timescale 1ns / 1ps
`default_nettype none

module dsad_window #(
   parameter int WINDOW_LENGTH = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   dsad_req_if.sink                  req_if,
   output logic                      avg_valid,
   input  wire logic                 avg_ready,
   output dsad_pkg::sample_type      avg
);
   import dsad_pkg::*;

   localparam int SAMPLE_W = $bits(sample_type);
   localparam int LEN_LOG  = $clog2(WINDOW_LENGTH);
   localparam int SUM_W    = SAMPLE_W + LEN_LOG;
   localparam int DIV_K    = SUM_W + LEN_LOG;
   localparam int RECIP_W  = SUM_W + 2;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
      ((64'd1 << DIV_K) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

   sample_type cell_out [WINDOW_LENGTH];

   logic             primed_ff, primed_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             sum_valid_ff, sum_valid_in;
   sample_type       avg_ff;
   logic             avg_valid_ff, avg_valid_in;

   logic             accept;
   logic             sum_ready;
   logic             avg_stage_ready;
   logic             avg_load;
   logic [PROD_W-1:0] quot_prod;

   assign avg_stage_ready = !avg_valid_ff || avg_ready;
   assign sum_ready       = !sum_valid_ff || avg_stage_ready;
   assign req_if.ready    = sum_ready;
   assign accept          = req_if.valid && sum_ready;
   assign avg_load        = sum_valid_ff && avg_stage_ready;

   for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         dsad_cell u_cell (
            .clock      (clock),
            .shift_en   (accept),
            .fill_en    (!primed_ff),
            .fill_value (req_if.adc_sample),
            .shift_in   (req_if.adc_sample),
            .shift_out  (cell_out[i])
         );
      end else begin : g_body
         dsad_cell u_cell (
            .clock      (clock),
            .shift_en   (accept),
            .fill_en    (!primed_ff),
            .fill_value (req_if.adc_sample),
            .shift_in   (cell_out[i-1]),
            .shift_out  (cell_out[i])
         );
      end
   end

   // first sample fills every cell, later ones drop the oldest
   always_comb begin
      primed_in    = primed_ff;
      sum_in       = sum_ff;
      if (accept) begin
         primed_in = 1'b1;
         if (primed_ff) begin
            sum_in = sum_ff - SUM_W'(cell_out[WINDOW_LENGTH-1])
                            + SUM_W'(req_if.adc_sample);
         end else begin
            sum_in = SUM_W'(req_if.adc_sample) * SUM_W'(WINDOW_LENGTH);
         end
      end
   end

   always_comb begin
      if (accept) begin
         sum_valid_in = 1'b1;
      end else if (avg_stage_ready) begin
         sum_valid_in = 1'b0;
      end else begin
         sum_valid_in = sum_valid_ff;
      end
      if (avg_load) begin
         avg_valid_in = 1'b1;
      end else if (avg_ready) begin
         avg_valid_in = 1'b0;
      end else begin
         avg_valid_in = avg_valid_ff;
      end
   end

   // exact divide by the window length through a reciprocal
   assign quot_prod = PROD_W'(sum_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         sum_ff       <= '0;
         sum_valid_ff <= 1'b0;
         avg_valid_ff <= 1'b0;
      end else begin
         primed_ff    <= primed_in;
         sum_ff       <= sum_in;
         sum_valid_ff <= sum_valid_in;
         avg_valid_ff <= avg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (avg_load) begin
         avg_ff <= quot_prod[DIV_K +: SAMPLE_W];
      end
   end

   assign avg_valid = avg_valid_ff;
   assign avg       = avg_ff;

   a_fill_sum: assert property (@(posedge clock) disable iff (reset)
      accept && !primed_ff |=>
         sum_ff == SUM_W'($past(req_if.adc_sample)) * SUM_W'(WINDOW_LENGTH))
      else $error("window sum not filled from first sample");

   a_primed_holds: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("window lost primed state");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> sum_valid_ff && avg_valid_ff)
      else $error("input stalled with an empty stage");

endmodule

`default_nettype wire

>>> rtl/dsad_scale.sv
// Voltage scaling and density pipeline with the result output register.
`timescale 1ns / 1ps
`default_nettype none

module dsad_scale #(
   parameter int SAMPLE_FULL_SCALE = 4095
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dsad_pkg::cfg_type    cfg,
   input  wire logic                 avg_valid,
   output logic                      avg_ready,
   input  wire dsad_pkg::sample_type avg,
   dsad_rsp_if.source                rsp_if
);
   import dsad_pkg::*;

   localparam int SAMPLE_W = $bits(sample_type);
   localparam int P_W      = SAMPLE_W + $bits(volt_type);
   localparam int VK       = P_W + $clog2(SAMPLE_FULL_SCALE);
   localparam int VRECIP_W = P_W + 2;
   localparam int VPROD_W  = P_W + VRECIP_W;
   localparam int QV_W     = VPROD_W - VK;
   localparam logic [VRECIP_W-1:0] VRECIP = VRECIP_W'(
      ((64'd1 << VK) + 64'(SAMPLE_FULL_SCALE) - 64'd1) / 64'(SAMPLE_FULL_SCALE));
   localparam int DPROD_W  = SCALED_W + DRECIP_W;

   // stage a: avg times full-scale voltage in 1/16 mV units
   logic [P_W-1:0]      prod_a_ff;
   sample_type          avg_a_ff;
   logic                va_ff, va_in;
   // stage b: voltage
   volt_type            volt_b_ff;
   sample_type          avg_b_ff;
   logic                vb_ff, vb_in;
   // stage c: excess over offset
   logic [SCALED_W-1:0] diff_c_ff;
   volt_type            volt_c_ff;
   sample_type          avg_c_ff;
   logic                vc_ff, vc_in;
   // stage d: output register
   dens_type            dens_d_ff;
   volt_type            volt_d_ff;
   sample_type          avg_d_ff;
   logic                vd_ff, vd_in;

   logic rdy_a, rdy_b, rdy_c, rdy_d;
   logic load_a, load_b, load_c, load_d;

   logic [VPROD_W-1:0]  vprod;
   logic [QV_W-1:0]     vquot;
   volt_type            volt_in;
   logic [SCALED_W-1:0] scaled;
   logic [SCALED_W-1:0] offset_q4;
   logic [SCALED_W-1:0] diff_in;
   logic [DPROD_W-1:0]  dprod;

   assign rdy_d     = !vd_ff || rsp_if.ready;
   assign rdy_c     = !vc_ff || rdy_d;
   assign rdy_b     = !vb_ff || rdy_c;
   assign rdy_a     = !va_ff || rdy_b;
   assign avg_ready = rdy_a;

   assign load_a = avg_valid && rdy_a;
   assign load_b = va_ff && rdy_b;
   assign load_c = vb_ff && rdy_c;
   assign load_d = vc_ff && rdy_d;

   always_comb begin
      va_in = load_a ? 1'b1 : (load_b ? 1'b0 : va_ff);
      vb_in = load_b ? 1'b1 : (load_c ? 1'b0 : vb_ff);
      vc_in = load_c ? 1'b1 : (load_d ? 1'b0 : vc_ff);
      vd_in = load_d ? 1'b1 : (rsp_if.ready ? 1'b0 : vd_ff);
   end

   // divide by converter full scale through a reciprocal, saturate to 16 bits
   assign vprod   = VPROD_W'(prod_a_ff) * VPROD_W'(VRECIP);
   assign vquot   = vprod[VK +: QV_W];
   assign volt_in = (32'(vquot) > 32'(VOLT_MAX)) ? VOLT_MAX : volt_type'(vquot);

   assign scaled    = SCALED_W'(volt_b_ff) * SCALED_W'(cfg.divider_gain);
   assign offset_q4 = SCALED_W'(cfg.density_offset_mv) << Q4_SHIFT;
   assign diff_in   = (scaled >= offset_q4) ? (scaled - offset_q4) : '0;

   // divide by five through a reciprocal
   assign dprod = DPROD_W'(diff_c_ff) * DPROD_W'(DENS_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
         vd_ff <= vd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         prod_a_ff <= P_W'(avg) * P_W'(MV_Q4);
         avg_a_ff  <= avg;
      end
      if (load_b) begin
         volt_b_ff <= volt_in;
         avg_b_ff  <= avg_a_ff;
      end
      if (load_c) begin
         diff_c_ff <= diff_in;
         volt_c_ff <= volt_b_ff;
         avg_c_ff  <= avg_b_ff;
      end
      if (load_d) begin
         dens_d_ff <= dens_type'(dprod[DENS_K +: DENS_Q_W]);
         volt_d_ff <= volt_c_ff;
         avg_d_ff  <= avg_c_ff;
      end
   end

   assign rsp_if.valid           = vd_ff;
   assign rsp_if.averaged_sample = avg_d_ff;
   assign rsp_if.voltage_q4      = volt_d_ff;
   assign rsp_if.density_q4      = dens_d_ff;

   a_zero_below_offset: assert property (@(posedge clock) disable iff (reset)
      load_d && diff_c_ff == '0 |=> dens_d_ff == '0)
      else $error("density not zero below offset");

   a_dens_bounded: assert property (@(posedge clock) disable iff (reset)
      load_d |=> dens_d_ff <= dens_type'($past(diff_c_ff)))
      else $error("density exceeds its excess voltage");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !avg_ready |-> va_ff && vb_ff && vc_ff && vd_ff)
      else $error("scale pipeline stalled with an empty stage");

endmodule

`default_nettype wire

>>> rtl/dust_sample_average_and_density.sv
// Dust sensor sample averager with voltage and density conversion.
//
// Each accepted beat on req_if carries one 12-bit converter sample; one beat
// comes out on rsp_if for every sample, in order. The block takes one sample
// per clock cycle when the result side keeps up. From accept to rsp_if.valid,
// a sample passes the window cells and running sum register, then the
// average register after the reciprocal multiply that divides by the window
// length, then the scale stages for the voltage scaling, gain/offset and
// divide-by-five multiplies. The first sample after reset fills the whole
// window. Registers on the csr port: index 0 is the density offset in mV,
// index 1 the divider gain; write them only while no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none

module dust_sample_average_and_density #(
   parameter int WINDOW_LENGTH     = 10,
   parameter int SAMPLE_FULL_SCALE = 4095
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   dsad_req_if.sink                     req_if,
   dsad_rsp_if.source                   rsp_if,
   input  wire logic                    csr_we,
   input  wire dsad_pkg::csr_index_type csr_index,
   input  wire dsad_pkg::csr_data_type  csr_wdata
);
   import dsad_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       avg_valid;
   logic       avg_ready;
   sample_type avg;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DENSITY_OFFSET: cfg_in.density_offset_mv = csr_wdata;
            CSR_DIVIDER_GAIN:   cfg_in.divider_gain = gain_type'(csr_wdata);
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.density_offset_mv <= OFFSET_RESET;
         cfg_ff.divider_gain      <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dsad_window #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .avg_valid (avg_valid),
      .avg_ready (avg_ready),
      .avg       (avg)
   );

   dsad_scale #(
      .SAMPLE_FULL_SCALE (SAMPLE_FULL_SCALE)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .avg_valid (avg_valid),
      .avg_ready (avg_ready),
      .avg       (avg),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire
